// ===== rtl/core/least_loaded_dispatcher_core_macros.svh =====
// Assertion macros used by the checker of the least-loaded dispatcher.
// Depends on nothing; included by the checker file.
`ifndef LEAST_LOADED_DISPATCHER_CORE_MACROS_SVH
`define LEAST_LOADED_DISPATCHER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define LLD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is active.
`define LLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/lld_pkg.sv =====
// Package of the least-loaded dispatcher: sizes, codes, reset costs and payload types.
// Depends on nothing; imported by every module of the block.
package lld_pkg;

    localparam int PROCESSORS = 4;
    localparam int PROC_IDX_W = (PROCESSORS > 1) ? $clog2(PROCESSORS) : 1;
    localparam int LOAD_W     = 32;
    localparam int COST_W     = 16;
    localparam int KIND_N     = 4;

    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

    // Configuration register indexes.
    localparam logic [1:0] CFG_COST_A = 2'd0;
    localparam logic [1:0] CFG_COST_B = 2'd1;
    localparam logic [1:0] CFG_COST_C = 2'd2;
    localparam logic [1:0] CFG_COST_D = 2'd3;

    // Operation codes.
    localparam logic OP_DISPATCH = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    localparam logic [COST_W-1:0] COST_A_RESET = 16'd5000;
    localparam logic [COST_W-1:0] COST_B_RESET = 16'd10000;
    localparam logic [COST_W-1:0] COST_C_RESET = 16'd15000;
    localparam logic [COST_W-1:0] COST_D_RESET = 16'd20000;

    typedef struct packed {
        logic       operation;
        logic [1:0] task_kind;
        logic [1:0] done_processor;
    } t_req;

    typedef struct packed {
        logic [1:0]        target_processor;
        logic [LOAD_W-1:0] updated_load;
        logic              clamp_flag;
    } t_res;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
    } t_ctrl_cmd;

endpackage

// ===== rtl/core/lld_ctrl.sv =====
// Controller of the least-loaded dispatcher: accepts a transaction and sequences the update.
// Depends on lld_pkg.
module lld_ctrl
    import lld_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    output t_ctrl_cmd o_cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy        = (r_state == ST_UPDATE);
    assign o_cmd.capture = (r_state == ST_IDLE) && i_start;
    assign o_cmd.update  = (r_state == ST_UPDATE);

endmodule

// ===== rtl/core/lld_datapath.sv =====
// Datapath of the least-loaded dispatcher: cost registers, load counters, argmin tree,
// saturating update and result register. Depends on lld_pkg.
module lld_datapath
    import lld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl_cmd   i_cmd,
    input  t_req        i_req,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_done,
    output t_res        o_res
);

    localparam int NODES = 1 << PROC_IDX_W;

    logic [COST_W-1:0]     r_cost [KIND_N];
    logic [LOAD_W-1:0]     r_cnt  [PROCESSORS];

    // Registered operands of the transaction in flight.
    logic                  r_op;
    logic [1:0]            r_proc;
    logic [PROC_IDX_W-1:0] r_idx;
    logic [LOAD_W-1:0]     r_load;
    logic [COST_W-1:0]     r_cost_sel;
    logic                  r_out_of_range;

    logic                  r_done;
    t_res                  r_res;

    logic [LOAD_W-1:0]     node_load [2*NODES];
    logic [PROC_IDX_W-1:0] node_idx  [2*NODES];
    logic                  node_vld  [2*NODES];

    logic [PROC_IDX_W-1:0] done_idx;
    logic                  done_in_range;
    logic [LOAD_W:0]       sum;
    logic [LOAD_W-1:0]     cost_ext;
    logic [LOAD_W-1:0]     n_load;
    logic                  n_flag;

    // Argmin as a binary tree; the left child holds lower indexes, so it wins on a tie.
    // Padding leaves past the last processor are invalid and never chosen.
    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            node_vld[NODES+i]  = (i < PROCESSORS);
            node_load[NODES+i] = (i < PROCESSORS) ? r_cnt[i % PROCESSORS] : LOAD_MAX;
            node_idx[NODES+i]  = PROC_IDX_W'(i);
        end
        node_vld[0]  = 1'b0;
        node_load[0] = LOAD_MAX;
        node_idx[0]  = '0;
        for (int n = NODES - 1; n >= 1; n--) begin
            if (node_vld[2*n+1] && (node_load[2*n+1] < node_load[2*n])) begin
                node_load[n] = node_load[2*n+1];
                node_idx[n]  = node_idx[2*n+1];
            end else begin
                node_load[n] = node_load[2*n];
                node_idx[n]  = node_idx[2*n];
            end
            node_vld[n] = node_vld[2*n] | node_vld[2*n+1];
        end
    end

    assign done_idx      = PROC_IDX_W'(i_req.done_processor);
    assign done_in_range = (32'(i_req.done_processor) < PROCESSORS);

    assign cost_ext = LOAD_W'(r_cost_sel);
    assign sum      = {1'b0, r_load} + {1'b0, cost_ext};

    always_comb begin
        n_load = '0;
        n_flag = 1'b0;
        if (r_op == OP_DISPATCH) begin
            if (sum[LOAD_W]) begin
                n_load = LOAD_MAX;
                n_flag = 1'b1;
            end else begin
                n_load = sum[LOAD_W-1:0];
            end
        end else if (!r_out_of_range) begin
            if (cost_ext > r_load) begin
                n_load = '0;
                n_flag = 1'b1;
            end else begin
                n_load = r_load - cost_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cost[CFG_COST_A] <= COST_A_RESET;
            r_cost[CFG_COST_B] <= COST_B_RESET;
            r_cost[CFG_COST_C] <= COST_C_RESET;
            r_cost[CFG_COST_D] <= COST_D_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COST_A: r_cost[CFG_COST_A] <= i_cfg_data;
                CFG_COST_B: r_cost[CFG_COST_B] <= i_cfg_data;
                CFG_COST_C: r_cost[CFG_COST_C] <= i_cfg_data;
                CFG_COST_D: r_cost[CFG_COST_D] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op           <= i_req.operation;
            r_proc         <= i_req.done_processor;
            r_cost_sel     <= r_cost[i_req.task_kind];
            if (i_req.operation == OP_DISPATCH) begin
                r_idx          <= node_idx[1];
                r_load         <= node_load[1];
                r_out_of_range <= 1'b0;
            end else begin
                r_idx          <= done_idx;
                r_load         <= done_in_range ? r_cnt[done_idx] : '0;
                r_out_of_range <= !done_in_range;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PROCESSORS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (i_cmd.update && !r_out_of_range) begin
            r_cnt[r_idx] <= n_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_res.target_processor <= (r_op == OP_DISPATCH) ? 2'(r_idx) : r_proc;
            r_res.updated_load     <= n_load;
            r_res.clamp_flag       <= n_flag;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/core/least_loaded_dispatcher_core.sv =====
// Top level of the least-loaded dispatcher: joins the controller and the datapath.
// Depends on lld_pkg, lld_ctrl and lld_datapath.
//
// Usage: a transaction is accepted at a rising edge with start high and busy low.
// i_req carries the operation, the task kind and, for a completion, the processor.
// A dispatch goes to the processor with the smallest pending load, lowest index on
// a tie, and adds the kind's cost with saturation; a completion subtracts the cost
// from the named processor, clamping at zero.
// Each transaction yields one result on o_res, marked by o_done for one cycle.
// After acceptance the controller enters its update state, and the result and o_done
// are registered from there. busy is high in that update state, which follows
// acceptance, so the block cannot take a new transaction until that update is done;
// the busy state covers the read-modify-write of one counter after the argmin at capture.
// The result is held in an output register, so the next transaction is accepted in
// the same cycle that the previous result is shown. The receiver cannot stall.
// Configuration: i_cfg_we writes i_cfg_data into cost register i_cfg_index at once;
// write only while idle.
// Reset (synchronous, active low) clears all load counters to zero, loads the default
// costs and returns the controller to idle.
module least_loaded_dispatcher_core
    import lld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_req        i_req,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_done,
    output t_res        o_res
);

    t_ctrl_cmd cmd;

    lld_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    lld_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_res       (o_res)
    );

endmodule

// ===== rtl/core/lld_checker.sv =====
// Port-level checker of the least-loaded dispatcher, bound to the top level.
// Depends on lld_pkg and least_loaded_dispatcher_core_macros.svh.
`include "least_loaded_dispatcher_core_macros.svh"

module lld_checker
    import lld_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input t_req i_req,
    input logic o_done,
    input t_res o_res
);

    // An accepted transaction makes the block busy in the next cycle.
    `LLD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // The busy cycle is always followed by the result strobe.
    `LLD_ASSERT_NEXT(a_busy_done, i_clk, i_rst_n, busy, o_done && !busy)

    // A result is never shown without a transaction in flight in the cycle before.
    `LLD_ASSERT_NOW(a_done_after_busy, i_clk, i_rst_n, o_done, $past(busy))

    // A completion echoes the processor named in the request.
    `LLD_ASSERT_NEXT(a_echo_proc, i_clk, i_rst_n,
        start && !busy && (i_req.operation == OP_COMPLETE),
        ##1 (o_res.target_processor == $past(i_req.done_processor, 2)))

endmodule

bind least_loaded_dispatcher_core lld_checker u_lld_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_req   (i_req),
    .o_done  (o_done),
    .o_res   (o_res)
);

// ===== dv/tb.sv =====
// Self-checking testbench of least_loaded_dispatcher_core: directed and random runs.
// Depends on lld_pkg and the RTL of the block; an in-bench load ledger predicts every result.
module tb;
    import lld_pkg::*;

    localparam int CLK_HALF          = 4;
    localparam int RUN_LIMIT         = 8 * 2_500_000;
    localparam int DRAIN_LIMIT       = 1000;
    localparam int ITEMS_PER_SETTING = 190;
    localparam int REPORT_LIMIT      = 10;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    localparam logic [1:0] KIND_A = 2'd0;
    localparam logic [1:0] KIND_B = 2'd1;
    localparam logic [1:0] KIND_C = 2'd2;
    localparam logic [1:0] KIND_D = 2'd3;

    // Mirrors the per-processor pending work and the cost registers, and keeps
    // the results owed by the block in order of acceptance.
    class load_ledger;
        logic [COST_W-1:0] cost [KIND_N];
        logic [LOAD_W-1:0] load [PROCESSORS];
        t_res              awaited [$];
        int                mismatches;

        function new();
            cost[CFG_COST_A] = COST_A_RESET;
            cost[CFG_COST_B] = COST_B_RESET;
            cost[CFG_COST_C] = COST_C_RESET;
            cost[CFG_COST_D] = COST_D_RESET;
            foreach (load[i]) load[i] = '0;
            mismatches = 0;
        endfunction

        function void set_cost(logic [1:0] idx, logic [COST_W-1:0] value);
            cost[idx] = value;
        endfunction

        function void note_request(t_req r);
            t_res              res;
            logic [LOAD_W:0]   sum;
            logic [LOAD_W-1:0] c;
            int                best;
            c = LOAD_W'(cost[r.task_kind]);
            res.clamp_flag = 1'b0;
            if (r.operation == OP_DISPATCH) begin
                best = 0;
                for (int i = 1; i < PROCESSORS; i++) begin
                    if (load[i] < load[best]) best = i;
                end
                sum = {1'b0, load[best]} + {1'b0, c};
                if (sum[LOAD_W]) begin
                    load[best] = LOAD_MAX;
                    res.clamp_flag = 1'b1;
                end else begin
                    load[best] = sum[LOAD_W-1:0];
                end
                res.target_processor = 2'(best);
                res.updated_load = load[best];
            end else if (int'(r.done_processor) >= PROCESSORS) begin
                res.target_processor = r.done_processor;
                res.updated_load = '0;
            end else begin
                if (c > load[r.done_processor]) begin
                    load[r.done_processor] = '0;
                    res.clamp_flag = 1'b1;
                end else begin
                    load[r.done_processor] = load[r.done_processor] - c;
                end
                res.target_processor = r.done_processor;
                res.updated_load = load[r.done_processor];
            end
            awaited.push_back(res);
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: proc %0d load %0d clamp %0b",
                             got.target_processor, got.updated_load, got.clamp_flag);
                return;
            end
            want = awaited.pop_front();
            if (got.target_processor !== want.target_processor ||
                got.updated_load !== want.updated_load ||
                got.clamp_flag !== want.clamp_flag) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("mismatch: expected proc %0d load %0d clamp %0b, got proc %0d load %0d clamp %0b",
                             want.target_processor, want.updated_load, want.clamp_flag,
                             got.target_processor, got.updated_load, got.clamp_flag);
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_done;
    t_res        o_res;

    load_ledger ledger;

    least_loaded_dispatcher_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_res       (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Values are read before the edge updates land, so acceptance and results
    // are seen exactly as the block sees them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) ledger.check_result(o_res);
            if (start && !busy) ledger.note_request(i_req);
        end
    end

    function automatic t_req make_req(logic op, logic [1:0] kind, logic [1:0] proc);
        t_req r;
        r.operation = op;
        r.task_kind = kind;
        r.done_processor = proc;
        return r;
    endfunction

    function automatic t_req random_req();
        t_req r;
        r.operation = 1'($urandom_range(0, 1));
        r.task_kind = 2'($urandom_range(0, 3));
        r.done_processor = 2'($urandom_range(0, 3));
        return r;
    endfunction

    // Holds the transaction on the inputs until the block takes it, then
    // returns at the following falling edge with start still high.
    task automatic issue(input t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (ledger.outstanding() > 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_costs(input logic [COST_W-1:0] a, input logic [COST_W-1:0] b,
                             input logic [COST_W-1:0] c, input logic [COST_W-1:0] d);
        logic [1:0]        idx  [KIND_N];
        logic [COST_W-1:0] vals [KIND_N];
        idx  = '{CFG_COST_A, CFG_COST_B, CFG_COST_C, CFG_COST_D};
        vals = '{a, b, c, d};
        wait_drained();
        i_cfg_we <= 1'b1;
        for (int k = 0; k < KIND_N; k++) begin
            i_cfg_index <= idx[k];
            i_cfg_data <= vals[k];
            ledger.set_cost(idx[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_bursts(input int count);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
                issue(random_req());
                burst--;
                left--;
            end
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    initial begin
        ledger = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_COST_A;
        i_cfg_data = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Default costs: ties go to the lowest index, exact and clamped subtracts.
        issue(make_req(OP_DISPATCH, KIND_A, 2'd0));
        issue(make_req(OP_DISPATCH, KIND_B, 2'd3));
        issue(make_req(OP_DISPATCH, KIND_C, 2'd1));
        issue(make_req(OP_DISPATCH, KIND_D, 2'd2));
        issue(make_req(OP_DISPATCH, KIND_A, 2'd0));
        issue(make_req(OP_DISPATCH, KIND_A, 2'd3));
        issue(make_req(OP_COMPLETE, KIND_D, 2'd3));
        issue(make_req(OP_COMPLETE, KIND_A, 2'd3));
        issue(make_req(OP_COMPLETE, KIND_B, 2'd0));
        issue(make_req(OP_COMPLETE, KIND_C, 2'd1));
        issue(make_req(OP_COMPLETE, KIND_A, 2'd2));
        issue(make_req(OP_COMPLETE, KIND_D, 2'd2));
        issue(make_req(OP_DISPATCH, KIND_D, 2'd1));

        // Zero cost leaves the counter alone; the largest cost goes both ways.
        set_costs('0, COST_MAX, 16'd1, 16'h8000);
        issue(make_req(OP_DISPATCH, KIND_A, 2'd2));
        issue(make_req(OP_COMPLETE, KIND_A, 2'd0));
        issue(make_req(OP_DISPATCH, KIND_B, 2'd0));
        issue(make_req(OP_COMPLETE, KIND_B, 2'd1));
        issue(make_req(OP_DISPATCH, KIND_C, 2'd3));
        issue(make_req(OP_COMPLETE, KIND_C, 2'd2));
        issue(make_req(OP_COMPLETE, KIND_D, 2'd3));

        run_bursts(ITEMS_PER_SETTING);
        set_costs('0, '0, '0, '0);
        run_bursts(ITEMS_PER_SETTING);
        set_costs(COST_MAX, COST_MAX, COST_MAX, COST_MAX);
        run_bursts(ITEMS_PER_SETTING);
        set_costs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        run_bursts(ITEMS_PER_SETTING);
        set_costs(COST_A_RESET, COST_B_RESET, COST_C_RESET, COST_D_RESET);
        run_bursts(ITEMS_PER_SETTING);
        set_costs(16'd1, 16'($urandom), COST_MAX, '0);
        run_bursts(ITEMS_PER_SETTING);

        // A short back-to-back tail at the largest costs.
        set_costs(COST_MAX, COST_MAX, COST_MAX, COST_MAX);
        repeat (16) issue(random_req());

        wait_drained();
        if (ledger.outstanding() > 0)
            $display("%0d transactions never produced a result", ledger.outstanding());
        if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("tb failed");
        $finish;
    end

endmodule
